FILE: rtl/drt_pkg.sv
// Shared types, codes and constants for the divider and reload timer.
// No dependencies; used by the step logic and the top level.
package drt_pkg;

  typedef enum logic [1:0] {
    MODE_ADVANCE = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_READ    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_DIV    = 2'd0,
    REG_CNT    = 2'd1,
    REG_RELOAD = 2'd2,
    REG_CTRL   = 2'd3
  } reg_sel_t;

  localparam int CNT_CD_W     = 12;
  localparam int CNT_PERIOD_W = 11;
  localparam int DIV_FLOOR_W  = 10;
  localparam int DIV_FLOOR    = -512;
  localparam int CNT_FLOOR    = -2048;
  localparam logic [7:0] CNT_MAX = 8'hFF;
  localparam int CTRL_EN_BIT  = 2;

  typedef struct packed {
    logic [7:0]                     divider;
    logic [7:0]                     counter;
    logic [7:0]                     reload;
    logic [7:0]                     control;
    logic signed [CNT_CD_W-1:0]     cnt_cd;
    logic [CNT_PERIOD_W-1:0]        cnt_period;
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] reg_select;
    logic [7:0] write_value;
    logic [7:0] elapsed_cycles;
  } item_t;

  function automatic logic [CNT_PERIOD_W-1:0] period_of(input logic [1:0] code);
    logic [CNT_PERIOD_W-1:0] p;
    case (code)
      2'd0:    p = CNT_PERIOD_W'(1024);
      2'd1:    p = CNT_PERIOD_W'(16);
      2'd2:    p = CNT_PERIOD_W'(64);
      default: p = CNT_PERIOD_W'(256);
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/drt_in_if.sv
// Input channel of the divider and reload timer: valid/ready plus one item.
// Depends on nothing.
interface drt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] reg_select;
  logic [7:0] write_value;
  logic [7:0] elapsed_cycles;

  modport source (output valid, output mode, output reg_select, output write_value,
                  output elapsed_cycles, input ready);
  modport sink   (input valid, input mode, input reg_select, input write_value,
                  input elapsed_cycles, output ready);
endinterface

FILE: rtl/drt_out_if.sv
// Result channel of the divider and reload timer: valid/ready plus one result.
// Depends on nothing.
interface drt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic       timer_irq;

  modport source (output valid, output read_value, output timer_irq, input ready);
  modport sink   (input valid, input read_value, input timer_irq, output ready);
endinterface

FILE: rtl/drt_step.sv
// Combinational step of the timer: next register state and result for one item.
// Depends on drt_pkg.
module drt_step #(
  parameter int DIV_PERIOD = 256,
  parameter int DCW        = 10
) (
  input  drt_pkg::item_t         item,
  input  drt_pkg::state_t        st,
  input  logic signed [DCW-1:0]  div_cd,
  output drt_pkg::state_t        st_nxt,
  output logic signed [DCW-1:0]  div_cd_nxt,
  output logic [7:0]             read_value,
  output logic                   timer_irq
);

  localparam int DXW = DCW + 2;
  localparam int CXW = drt_pkg::CNT_CD_W + 1;

  logic signed [DXW-1:0] div_diff, div_sat, div_sum;
  logic signed [CXW-1:0] cnt_diff, cnt_sat, cnt_sum;
  logic [drt_pkg::CNT_PERIOD_W-1:0] new_period;

  always_comb begin
    div_diff = DXW'(div_cd) - $signed({{(DXW-8){1'b0}}, item.elapsed_cycles});
    div_sat  = (div_diff < DXW'(drt_pkg::DIV_FLOOR)) ? DXW'(drt_pkg::DIV_FLOOR) : div_diff;
    div_sum  = div_sat + DXW'(DIV_PERIOD);

    cnt_diff = CXW'(st.cnt_cd) - $signed({{(CXW-8){1'b0}}, item.elapsed_cycles});
    cnt_sat  = (cnt_diff < CXW'(drt_pkg::CNT_FLOOR)) ? CXW'(drt_pkg::CNT_FLOOR) : cnt_diff;
    cnt_sum  = cnt_sat + $signed({{(CXW-drt_pkg::CNT_PERIOD_W){1'b0}}, st.cnt_period});

    new_period = item.write_value[drt_pkg::CTRL_EN_BIT] ?
                 drt_pkg::period_of(item.write_value[1:0]) : '0;
  end

  always_comb begin
    st_nxt     = st;
    div_cd_nxt = div_cd;
    read_value = 8'd0;
    timer_irq  = 1'b0;
    case (drt_pkg::mode_t'(item.mode))
      drt_pkg::MODE_ADVANCE: begin
        if (div_sat <= 0) begin
          st_nxt.divider = st.divider + 8'd1;
          div_cd_nxt     = $signed(div_sum[DCW-1:0]);
        end else begin
          div_cd_nxt     = $signed(div_sat[DCW-1:0]);
        end
        if (st.cnt_period != '0) begin
          if (cnt_sat <= 0) begin
            if (st.counter == drt_pkg::CNT_MAX) begin
              st_nxt.counter = st.reload;
              timer_irq      = 1'b1;
            end else begin
              st_nxt.counter = st.counter + 8'd1;
            end
            st_nxt.cnt_cd = $signed(cnt_sum[drt_pkg::CNT_CD_W-1:0]);
          end else begin
            st_nxt.cnt_cd = $signed(cnt_sat[drt_pkg::CNT_CD_W-1:0]);
          end
        end
      end
      drt_pkg::MODE_WRITE: begin
        unique case (drt_pkg::reg_sel_t'(item.reg_select))
          drt_pkg::REG_DIV:    st_nxt.divider = 8'd0;
          drt_pkg::REG_CNT:    st_nxt.counter = item.write_value;
          drt_pkg::REG_RELOAD: st_nxt.reload  = item.write_value;
          drt_pkg::REG_CTRL: begin
            st_nxt.control    = item.write_value;
            st_nxt.cnt_period = new_period;
            st_nxt.cnt_cd     = $signed({{(drt_pkg::CNT_CD_W-drt_pkg::CNT_PERIOD_W){1'b0}},
                                         new_period});
          end
          default: st_nxt = st;
        endcase
      end
      drt_pkg::MODE_READ: begin
        unique case (drt_pkg::reg_sel_t'(item.reg_select))
          drt_pkg::REG_DIV:    read_value = st.divider;
          drt_pkg::REG_CNT:    read_value = st.counter;
          drt_pkg::REG_RELOAD: read_value = st.reload;
          drt_pkg::REG_CTRL:   read_value = st.control;
          default:             read_value = 8'd0;
        endcase
      end
      default: begin
        read_value = 8'd0;
      end
    endcase
  end

endmodule

FILE: rtl/divider_and_reload_timer.sv
// Top level of the divider and reload timer: input register, step logic, result register.
// Depends on drt_pkg, drt_in_if, drt_out_if and drt_step.
//
// Timer with a free-running divider (incremented as its DIV_PERIOD countdown runs out) and a
// counter with selectable period and reload; each item advances time, writes or
// reads a register and yields one result. One item is accepted per clock unless
// a held result stalls the input; each item passes the input register, then the
// result register, with the state updated by one pass of subtract-and-compare
// logic between them. A result held by the receiver stalls the input register
// and then the input. The valid flags, the state and the divider countdown reset
// to zero; the item and result registers are not reset.
module divider_and_reload_timer #(
  parameter int DIV_PERIOD = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  drt_in_if.sink           in_ch,
  drt_out_if.source        out_ch
);

  localparam int DCW_P = $clog2(DIV_PERIOD + 1) + 1;
  localparam int DCW   = (DCW_P > drt_pkg::DIV_FLOOR_W) ? DCW_P : drt_pkg::DIV_FLOOR_W;

  logic                   s1_valid_r;
  drt_pkg::item_t         s1_item_r;
  drt_pkg::state_t        state_r, state_nxt;
  logic signed [DCW-1:0]  div_cd_r, div_cd_nxt;
  logic                   out_valid_r;
  logic [7:0]             out_read_r, read_nxt;
  logic                   out_irq_r, irq_nxt;
  logic                   advance;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;

  drt_step #(
    .DIV_PERIOD (DIV_PERIOD),
    .DCW        (DCW)
  ) u_step (
    .item       (s1_item_r),
    .st         (state_r),
    .div_cd     (div_cd_r),
    .st_nxt     (state_nxt),
    .div_cd_nxt (div_cd_nxt),
    .read_value (read_nxt),
    .timer_irq  (irq_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      div_cd_r    <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_valid_r && advance) begin
        state_r  <= state_nxt;
        div_cd_r <= div_cd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.mode           <= in_ch.mode;
      s1_item_r.reg_select     <= in_ch.reg_select;
      s1_item_r.write_value    <= in_ch.write_value;
      s1_item_r.elapsed_cycles <= in_ch.elapsed_cycles;
    end
    if (s1_valid_r && advance) begin
      out_read_r <= read_nxt;
      out_irq_r  <= irq_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_read_r;
  assign out_ch.timer_irq  = out_irq_r;

endmodule
